### src/eri_pkg.sv
package eri_pkg;

   localparam int MEM_WORDS = 65536;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int REG_COUNT = 8;
   localparam int RF_AW     = $clog2(REG_COUNT);
   localparam int XLEN      = 32;
   localparam int PC_W      = 16;
   localparam int LEN_W     = PC_W + 1;

   localparam int OP_LSB  = 22;
   localparam int RA_LSB  = 19;
   localparam int RB_LSB  = 16;
   localparam int RD_LSB  = 0;
   localparam int OFF_LSB = 0;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_STEP,
      CMD_READ_REG,
      CMD_READ_MEM
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_RUN,
      STAT_HALT,
      STAT_PAST_END
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_NOR,
      OP_LW,
      OP_SW,
      OP_BEQ,
      OP_JALR,
      OP_HALT,
      OP_NOOP
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_LWDATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic [15:0]        address;
      logic signed [31:0] data;
      logic [2:0]         reg_index;
   } req_word_type;

   typedef struct packed {
      logic [15:0]        pc_value;
      status_type         status;
      logic signed [31:0] read_data;
   } rsp_word_type;

   typedef struct packed {
      logic              a_en;
      logic [RF_AW-1:0]  a_addr;
      logic              b_en;
      logic [RF_AW-1:0]  b_addr;
      logic              wr_en;
      logic [RF_AW-1:0]  wr_addr;
      logic [XLEN-1:0]   wr_data;
   } rf_ctl_type;

endpackage

### src/eri_regfile.sv
module eri_regfile (
   input  logic                 clock,
   input  logic                 reset,
   input  eri_pkg::rf_ctl_type  rf_ctl,
   output logic [eri_pkg::XLEN-1:0] a_data,
   output logic [eri_pkg::XLEN-1:0] b_data
);
   import eri_pkg::*;

   logic [XLEN-1:0]      rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [REG_COUNT-1:0] valid_in;
   logic [XLEN-1:0]      a_raw_ff;
   logic [XLEN-1:0]      b_raw_ff;
   logic                 a_valid_ff;
   logic                 b_valid_ff;

   // Registers read as zero until their first write.
   always_comb begin
      valid_in = valid_ff;
      if (rf_ctl.wr_en) begin
         valid_in[rf_ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_ctl.wr_en) begin
         rf_mem[rf_ctl.wr_addr] <= rf_ctl.wr_data;
      end
      if (rf_ctl.a_en) begin
         a_raw_ff   <= rf_mem[rf_ctl.a_addr];
         a_valid_ff <= valid_ff[rf_ctl.a_addr];
      end
      if (rf_ctl.b_en) begin
         b_raw_ff   <= rf_mem[rf_ctl.b_addr];
         b_valid_ff <= valid_ff[rf_ctl.b_addr];
      end
   end

   assign a_data = a_valid_ff ? a_raw_ff : '0;
   assign b_data = b_valid_ff ? b_raw_ff : '0;

endmodule

### src/eight_register_isa_executor.sv
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+-----------------------------------
// request   | start, busy, req_word         | taken when start is high, busy low
// response  | rsp_strobe, rsp_word          | one word per request, strobe 1 cycle
//
// A load, register read or memory read, or a step on a stopped machine, strobes
// its response in the cycle after acceptance. A running step passes through
// ST_FETCH, ST_EXEC, ST_LWDATA (for a load word only) and ST_DONE, since the fetch,
// the register reads and the data access each pass a synchronous memory. Reset
// clears the registers, the pc, the length and the halt flag, with no clearing
// pass; the response cannot stall.
module eight_register_isa_executor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  eri_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output eri_pkg::rsp_word_type rsp_word
);
   import eri_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   cmd_type          cmd_ff;
   logic [XLEN-1:0]  instr_ff;
   logic [PC_W-1:0]  pc_ff;
   logic [PC_W-1:0]  pc_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic             halted_ff;
   logic             halted_in;

   logic [XLEN-1:0]   word_mem [MEM_WORDS];
   logic [XLEN-1:0]   mem_rdata_ff;
   logic              mem_re;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_addr;
   logic [XLEN-1:0]   mem_wdata;

   rf_ctl_type      rf_ctl;
   logic [XLEN-1:0] ra_val;
   logic [XLEN-1:0] rb_val;

   logic              accept;
   logic              running;
   opcode_type        op;
   logic [RF_AW-1:0]  ra_idx;
   logic [RF_AW-1:0]  rb_idx;
   logic [RF_AW-1:0]  rd_idx;
   logic [PC_W-1:0]   offset;
   logic [PC_W-1:0]   pc_next;
   logic [LEN_W-1:0]  pc_plus_wide;
   logic [MEM_AW-1:0] data_addr;
   logic [LEN_W-1:0]  load_len;
   status_type        status;

   eri_regfile u_regfile (
      .clock  (clock),
      .reset  (reset),
      .rf_ctl (rf_ctl),
      .a_data (ra_val),
      .b_data (rb_val)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign running = !halted_ff && ({1'b0, pc_ff} < len_ff);

   assign op           = opcode_type'(instr_ff[OP_LSB +: 3]);
   assign ra_idx       = instr_ff[RA_LSB +: RF_AW];
   assign rb_idx       = instr_ff[RB_LSB +: RF_AW];
   assign rd_idx       = instr_ff[RD_LSB +: RF_AW];
   assign offset       = instr_ff[OFF_LSB +: PC_W];
   assign pc_next      = pc_ff + PC_W'(1);
   assign pc_plus_wide = LEN_W'(pc_ff) + LEN_W'(1);
   assign data_addr    = ra_val[MEM_AW-1:0] + offset[MEM_AW-1:0];
   assign load_len     = LEN_W'(req_word.address[MEM_AW-1:0]) + LEN_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_word.command == CMD_STEP && running) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (op == OP_LW) ? ST_LWDATA : ST_DONE;
         end
         ST_LWDATA: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = req_word.address[MEM_AW-1:0];
      mem_wdata = req_word.data;
      rf_ctl    = '0;
      pc_in     = pc_ff;
      len_in    = len_ff;
      halted_in = halted_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_word.command)
                  CMD_LOAD: begin
                     mem_we = 1'b1;
                     if (load_len > len_ff) begin
                        len_in = load_len;
                     end
                  end
                  CMD_STEP: begin
                     mem_re   = running;
                     mem_addr = pc_ff[MEM_AW-1:0];
                  end
                  CMD_READ_REG: begin
                     rf_ctl.a_en   = 1'b1;
                     rf_ctl.a_addr = req_word.reg_index[RF_AW-1:0];
                  end
                  CMD_READ_MEM: begin
                     mem_re = 1'b1;
                  end
                  default: begin
                     mem_re = 1'b0;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            rf_ctl.a_en   = 1'b1;
            rf_ctl.a_addr = mem_rdata_ff[RA_LSB +: RF_AW];
            rf_ctl.b_en   = 1'b1;
            rf_ctl.b_addr = mem_rdata_ff[RB_LSB +: RF_AW];
         end
         ST_EXEC: begin
            pc_in = pc_next;
            unique case (op)
               OP_ADD: begin
                  rf_ctl.wr_en   = 1'b1;
                  rf_ctl.wr_addr = rd_idx;
                  rf_ctl.wr_data = ra_val + rb_val;
               end
               OP_NOR: begin
                  rf_ctl.wr_en   = 1'b1;
                  rf_ctl.wr_addr = rd_idx;
                  rf_ctl.wr_data = ~(ra_val | rb_val);
               end
               OP_LW: begin
                  mem_re   = 1'b1;
                  mem_addr = data_addr;
               end
               OP_SW: begin
                  mem_we    = 1'b1;
                  mem_addr  = data_addr;
                  mem_wdata = rb_val;
               end
               OP_BEQ: begin
                  if (ra_val == rb_val) begin
                     pc_in = pc_next + offset;
                  end
               end
               OP_JALR: begin
                  rf_ctl.wr_en   = 1'b1;
                  rf_ctl.wr_addr = rb_idx;
                  rf_ctl.wr_data = XLEN'(pc_plus_wide);
                  pc_in = (ra_idx == rb_idx) ? pc_next : ra_val[PC_W-1:0];
               end
               OP_HALT: begin
                  halted_in = 1'b1;
               end
               default: begin
                  halted_in = halted_ff;
               end
            endcase
         end
         ST_LWDATA: begin
            rf_ctl.wr_en   = 1'b1;
            rf_ctl.wr_addr = rb_idx;
            rf_ctl.wr_data = mem_rdata_ff;
         end
         ST_DONE: begin
            mem_re = 1'b0;
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         len_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         len_ff    <= len_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_word.command;
      end
      if (state_ff == ST_FETCH) begin
         instr_ff <= mem_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= word_mem[mem_addr];
      end
   end

   always_comb begin
      if (halted_ff) begin
         status = STAT_HALT;
      end else if ({1'b0, pc_ff} >= len_ff) begin
         status = STAT_PAST_END;
      end else begin
         status = STAT_RUN;
      end
   end

   assign rsp_strobe        = (state_ff == ST_DONE);
   assign rsp_word.pc_value = pc_ff;
   assign rsp_word.status   = status;

   always_comb begin
      case (cmd_ff)
         CMD_READ_REG: rsp_word.read_data = ra_val;
         CMD_READ_MEM: rsp_word.read_data = mem_rdata_ff;
         default:      rsp_word.read_data = '0;
      endcase
   end

endmodule

### src/eri_checker.sv
module eri_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input eri_pkg::req_word_type req_word,
   input logic                  rsp_strobe,
   input eri_pkg::rsp_word_type rsp_word
);
   import eri_pkg::*;

   logic unused_payload;

   assign unused_payload = ^{req_word, rsp_word};

   // Every accepted word keeps the block busy in the following cycle.
   accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   // A response is only shown while a request is in flight.
   strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while idle");

   // Each response lasts one cycle and the block is free right after it.
   strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response strobe not followed by an idle cycle");

   // Once the machine reports halted, a response that follows as soon as the block allows reports it too.
   halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == STAT_HALT) |=> ##1
      (!rsp_strobe || rsp_word.status == STAT_HALT))
      else $error("halted status was lost");

endmodule

bind eight_register_isa_executor eri_checker u_eri_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

### test/tb_eight_register_isa_executor.sv
`timescale 1ns / 100ps

module tb_eight_register_isa_executor;
   import eri_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   logic [31:0]  reg_image [REG_COUNT];
   logic [31:0]  mem_image [logic [15:0]];
   logic [15:0]  written_addrs[$];
   logic [15:0]  pc_image;
   logic [16:0]  len_image;
   logic         halt_image;

   rsp_word_type due_reports[$];
   bit           idle_on;
   int           loads_done;
   int           steps_done;
   int           reads_done;
   int           checked;
   int           mismatches;

   eight_register_isa_executor u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic status_type machine_status();
      if (halt_image) begin
         return STAT_HALT;
      end
      if ({1'b0, pc_image} >= len_image) begin
         return STAT_PAST_END;
      end
      return STAT_RUN;
   endfunction

   function automatic rsp_word_type run_command(req_word_type w);
      rsp_word_type r;
      logic [31:0]  insn;
      logic [31:0]  target;
      logic [2:0]   ra;
      logic [2:0]   rb;
      logic [15:0]  next_pc;
      r.read_data = '0;
      case (w.command)
         CMD_LOAD: begin
            loads_done++;
            mem_image[w.address] = w.data;
            written_addrs.push_back(w.address);
            if ({1'b0, w.address} + 17'd1 > len_image) begin
               len_image = {1'b0, w.address} + 17'd1;
            end
         end
         CMD_STEP: begin
            steps_done++;
            if (machine_status() == STAT_RUN) begin
               insn    = mem_image[pc_image];
               ra      = insn[RA_LSB +: 3];
               rb      = insn[RB_LSB +: 3];
               target  = reg_image[ra] + {{16{insn[15]}}, insn[15:0]};
               next_pc = pc_image + 16'd1;
               case (opcode_type'(insn[OP_LSB +: 3]))
                  OP_ADD: reg_image[insn[RD_LSB +: 3]] = reg_image[ra] + reg_image[rb];
                  OP_NOR: reg_image[insn[RD_LSB +: 3]] = ~(reg_image[ra] | reg_image[rb]);
                  OP_LW: reg_image[rb] = mem_image[target[15:0]];
                  OP_SW: begin
                     mem_image[target[15:0]] = reg_image[rb];
                     written_addrs.push_back(target[15:0]);
                  end
                  OP_BEQ: begin
                     if (reg_image[ra] == reg_image[rb]) begin
                        next_pc = pc_image + 16'd1 + insn[15:0];
                     end
                  end
                  OP_JALR: begin
                     reg_image[rb] = {16'd0, pc_image} + 32'd1;
                     next_pc = reg_image[ra][15:0];
                  end
                  OP_HALT: halt_image = 1'b1;
                  default: ;
               endcase
               pc_image = next_pc;
            end
         end
         CMD_READ_REG: begin
            reads_done++;
            r.read_data = reg_image[w.reg_index];
         end
         default: begin
            reads_done++;
            r.read_data = mem_image[w.address];
         end
      endcase
      r.pc_value = pc_image;
      r.status   = machine_status();
      return r;
   endfunction

   function automatic logic [31:0] make_insn(opcode_type op, logic [2:0] ra, logic [2:0] rb,
                                             logic [15:0] low);
      logic [31:0] w;
      w = $urandom;
      w[OP_LSB +: 3] = op;
      w[RA_LSB +: 3] = ra;
      w[RB_LSB +: 3] = rb;
      w[15:0] = low;
      return w;
   endfunction

   function automatic logic [31:0] random_insn();
      int          pick;
      opcode_type  op;
      logic [2:0]  ra;
      logic [2:0]  rb;
      logic [15:0] low;
      pick = $urandom_range(0, 99);
      ra   = 3'($urandom);
      rb   = 3'($urandom);
      low  = 16'($urandom);
      if (pick < 18) op = OP_ADD;
      else if (pick < 34) op = OP_NOR;
      else if (pick < 50) op = OP_LW;
      else if (pick < 66) op = OP_SW;
      else if (pick < 82) op = OP_BEQ;
      else if (pick < 90) op = OP_JALR;
      else op = OP_NOOP;
      if (op == OP_BEQ) begin
         if (pick[0]) begin
            rb = ra;
         end
         if ($urandom_range(0, 3) != 0) begin
            low = 16'($urandom_range(0, 16)) - 16'd8;
         end
      end
      return make_insn(op, ra, rb, low);
   endfunction

   task automatic send_word(input req_word_type w);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      due_reports.push_back(run_command(w));
   endtask

   task automatic send_fields(cmd_type c, logic [15:0] a, logic [31:0] d, logic [2:0] ri);
      req_word_type w;
      w.command   = c;
      w.address   = a;
      w.data      = d;
      w.reg_index = ri;
      send_word(w);
   endtask

   task automatic load_word(logic [15:0] a, logic [31:0] d);
      send_fields(CMD_LOAD, a, d, 3'($urandom));
   endtask

   task automatic step_machine();
      send_fields(CMD_STEP, 16'($urandom), $urandom, 3'($urandom));
   endtask

   task automatic read_reg(logic [2:0] ri);
      send_fields(CMD_READ_REG, 16'($urandom), $urandom, ri);
   endtask

   task automatic read_mem(logic [15:0] a);
      send_fields(CMD_READ_MEM, a, $urandom, 3'($urandom));
   endtask

   // The fetched word, and the word that a load word instruction reads, must
   // already be in memory, so either is written first when it is missing.
   task automatic safe_step();
      logic [31:0] insn;
      logic [31:0] target;
      if (machine_status() == STAT_RUN) begin
         if (!mem_image.exists(pc_image)) begin
            load_word(pc_image, random_insn());
         end
         insn   = mem_image[pc_image];
         target = reg_image[insn[RA_LSB +: 3]] + {{16{insn[15]}}, insn[15:0]};
         if (opcode_type'(insn[OP_LSB +: 3]) == OP_LW && !mem_image.exists(target[15:0])) begin
            load_word(target[15:0], $urandom);
         end
      end
      step_machine();
   endtask

   task automatic test_reset_state();
      step_machine();
      read_reg(3'd7);
   endtask

   // A short program that touches every opcode but halt and noop, branches backward
   // across address zero, and then returns through a jump at the top word.
   task automatic test_program();
      load_word(16'd0, make_insn(OP_LW, 3'd0, 3'd1, 16'd40));
      load_word(16'd1, make_insn(OP_LW, 3'd0, 3'd2, 16'd41));
      load_word(16'd2, make_insn(OP_ADD, 3'd1, 3'd2, {13'($urandom), 3'd3}));
      load_word(16'd3, make_insn(OP_NOR, 3'd0, 3'd0, {13'($urandom), 3'd0}));
      load_word(16'd4, make_insn(OP_SW, 3'd0, 3'd2, 16'h7FFF));
      load_word(16'd5, make_insn(OP_JALR, 3'd6, 3'd6, 16'($urandom)));
      load_word(16'd6, make_insn(OP_BEQ, 3'd1, 3'd1, 16'hFFF8));
      load_word(16'd40, 32'h8000_0000);
      load_word(16'd41, 32'h7FFF_FFFF);
      repeat (8) step_machine();
      load_word(16'hFFFF, make_insn(OP_JALR, 3'd7, 3'd5, 16'($urandom)));
      step_machine();
      read_reg(3'd5);
      read_reg(3'd0);
      read_mem(16'h7FFE);
   endtask

   task automatic test_random(int count, bit with_idle);
      int pick;
      for (int i = 0; i < count; i++) begin
         idle_on = with_idle && (i % 80) < 60;
         pick    = $urandom_range(0, 99);
         if (pick < 58) safe_step();
         else if (pick < 70) load_word(pc_image + 16'($urandom_range(0, 3)), random_insn());
         else if (pick < 77) load_word(16'($urandom), $urandom);
         else if (pick < 88) read_reg(3'($urandom));
         else read_mem(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
      end
   endtask

   task automatic test_halt();
      load_word(pc_image, make_insn(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom)));
      step_machine();
      step_machine();
      load_word(16'($urandom), $urandom);
      read_reg(3'($urandom));
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (due_reports.size() == 0) begin
            mismatches++;
            $display("%0t: response %h arrived with no command outstanding", $time, rsp_word);
         end else begin
            want = due_reports.pop_front();
            checked++;
            if (rsp_word.pc_value !== want.pc_value) begin
               mismatches++;
               if (mismatches < 60) begin
                  $display("%0t: pc_value expected %h, got %h", $time, want.pc_value,
                           rsp_word.pc_value);
               end
            end
            if (rsp_word.status !== want.status) begin
               mismatches++;
               if (mismatches < 60) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status,
                           rsp_word.status);
               end
            end
            if (rsp_word.read_data !== want.read_data) begin
               mismatches++;
               if (mismatches < 60) begin
                  $display("%0t: read_data expected %h, got %h", $time, want.read_data,
                           rsp_word.read_data);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      foreach (reg_image[i]) reg_image[i] = '0;
      pc_image   = '0;
      len_image  = '0;
      halt_image = 1'b0;
      idle_on    = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_program();
      test_random(310, 1'b1);
      test_random(100, 1'b0);
      idle_on = 1'b0;
      test_halt();
      start <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d loads, %0d steps and %0d reads; %0d responses checked.",
               loads_done, steps_done, reads_done, checked);
      $display("Covered every opcode, branch and pc wrap, past-end and halted steps.");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
